// ===== src/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg : shared types and constants for the ray/triangle pipeline
// Fixed-point widths of every intermediate, register indexes, payload
// structs and small multiply helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

  // Fraction bits of the Q format
  localparam int FRAC_BITS = 16;

  // Coordinate, edge, product and cross-product widths
  localparam int W_C  = 32;
  localparam int W_E  = W_C + 1;
  localparam int W_P  = 2 * W_E;
  localparam int W_X  = W_P + 1;
  // Cross-product split for the dot-product multipliers
  localparam int W_LO = (W_X + 1) / 2;
  localparam int W_HI = W_X - W_LO;
  localparam int W_PL = W_E + W_LO + 1;
  localparam int W_PH = W_E + W_HI;
  // Dot products, with headroom for the three-term sum
  localparam int W_D  = W_X + W_E + 4;

  // Distance output
  localparam int DIST_W = 31;
  localparam int SAT_SH = DIST_W - FRAC_BITS;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Configuration port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST    = 3'd6;

  typedef logic [W_C-1:0] coord_t;
  typedef logic [W_E-1:0] edge_t;
  typedef logic [W_P-1:0] prod_t;
  typedef logic [W_X-1:0] cross_t;
  typedef logic [W_D-1:0] wide_t;

  // Triangle word as it enters
  typedef struct packed {
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] c;
    logic         last;
  } rti_tri_t;

  // Edges and origin offset
  typedef struct packed {
    edge_t [2:0] e1;
    edge_t [2:0] e2;
    edge_t [2:0] s;
    logic        last;
  } rti_edge_t;

  // Edges plus both cross products
  typedef struct packed {
    edge_t  [2:0] e1;
    edge_t  [2:0] e2;
    edge_t  [2:0] s;
    cross_t [2:0] h;
    cross_t [2:0] q;
    logic         last;
  } rti_geo_t;

  // Sign-normalised determinant and distance numerator, with test results
  typedef struct packed {
    wide_t det;
    wide_t t;
    logic  pass;
    logic  sat;
    logic  last;
  } rti_cmp_t;

  function automatic prod_t mul_s(input edge_t x, input edge_t y);
    logic signed [W_P-1:0] r;
    r = $signed(x) * $signed(y);
    return r;
  endfunction

  function automatic logic [W_PL-1:0] mul_lo(input edge_t x, input logic [W_LO-1:0] y);
    logic signed [W_PL-1:0] r;
    r = $signed(x) * $signed({1'b0, y});
    return r;
  endfunction

  function automatic logic [W_PH-1:0] mul_hi(input edge_t x, input logic [W_HI-1:0] y);
    logic signed [W_PH-1:0] r;
    r = $signed(x) * $signed(y);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/rti_front.sv =====
// ----------------------------------------------------------------------------
// rti_front : edges and cross products
// Three stages: edge differences, the twelve products, the two cross
// products h = dir x e2 and q = s x e1.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_vld,
  input  wire rti_pkg::rti_tri_t         tri_in,
  input  wire rti_pkg::coord_t [2:0]     org,
  input  wire rti_pkg::coord_t [2:0]     dir,
  input  wire logic                      dn_en,
  output logic                           up_en,
  output logic                           out_vld,
  output rti_pkg::rti_geo_t              geo_out
);

  logic [2:0] v_r;
  logic [2:0] en;

  rti_pkg::rti_edge_t             s1_nxt, s1_r, s2_r;
  rti_pkg::prod_t [2:0][1:0]      hp_nxt, qp_nxt, hp_r, qp_r;
  rti_pkg::rti_geo_t              s3_nxt, s3_r;
  rti_pkg::edge_t [2:0]           dext;

  assign en[2] = !v_r[2] || dn_en;
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign up_en = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_vld;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  // stage 1: differences, 33-bit exact
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_nxt.e1[i] = {tri_in.b[i][rti_pkg::W_C-1], tri_in.b[i]}
                   - {tri_in.a[i][rti_pkg::W_C-1], tri_in.a[i]};
      s1_nxt.e2[i] = {tri_in.c[i][rti_pkg::W_C-1], tri_in.c[i]}
                   - {tri_in.a[i][rti_pkg::W_C-1], tri_in.a[i]};
      s1_nxt.s[i]  = {org[i][rti_pkg::W_C-1], org[i]}
                   - {tri_in.a[i][rti_pkg::W_C-1], tri_in.a[i]};
      dext[i]      = {dir[i][rti_pkg::W_C-1], dir[i]};
    end
    s1_nxt.last = tri_in.last;
  end

  // stage 2: products; stage 3: cross differences
  for (genvar j = 0; j < 3; j++) begin : g_cross
    localparam int J1 = (j + 1) % 3;
    localparam int J2 = (j + 2) % 3;
    assign hp_nxt[j][0] = rti_pkg::mul_s(dext[J1], s1_r.e2[J2]);
    assign hp_nxt[j][1] = rti_pkg::mul_s(dext[J2], s1_r.e2[J1]);
    assign qp_nxt[j][0] = rti_pkg::mul_s(s1_r.s[J1], s1_r.e1[J2]);
    assign qp_nxt[j][1] = rti_pkg::mul_s(s1_r.s[J2], s1_r.e1[J1]);
    assign s3_nxt.h[j] = {hp_r[j][0][rti_pkg::W_P-1], hp_r[j][0]}
                       - {hp_r[j][1][rti_pkg::W_P-1], hp_r[j][1]};
    assign s3_nxt.q[j] = {qp_r[j][0][rti_pkg::W_P-1], qp_r[j][0]}
                       - {qp_r[j][1][rti_pkg::W_P-1], qp_r[j][1]};
  end

  assign s3_nxt.e1   = s2_r.e1;
  assign s3_nxt.e2   = s2_r.e2;
  assign s3_nxt.s    = s2_r.s;
  assign s3_nxt.last = s2_r.last;

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
    if (en[1]) begin
      s2_r <= s1_r;
      hp_r <= hp_nxt;
      qp_r <= qp_nxt;
    end
    if (en[2]) s3_r <= s3_nxt;
  end

  assign out_vld = v_r[2];
  assign geo_out = s3_r;

endmodule

`default_nettype wire

// ===== src/rti_dot.sv =====
// ----------------------------------------------------------------------------
// rti_dot : dot products, sign normalisation and inside tests
// Five stages: split partial products, component sums, three-term sums,
// negation to a positive determinant, barycentric / distance tests.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_dot (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_vld,
  input  wire rti_pkg::rti_geo_t         geo_in,
  input  wire rti_pkg::coord_t [2:0]     dir,
  input  wire logic                      dn_en,
  output logic                           up_en,
  output logic                           out_vld,
  output rti_pkg::rti_cmp_t              cmp_out
);

  localparam int W_D = rti_pkg::W_D;

  logic [4:0] v_r;
  logic [4:0] en;

  // dot k: 0 det = e1.h, 1 u = s.h, 2 v = dir.q, 3 t = e2.q
  rti_pkg::edge_t  [3:0][2:0]              va;
  rti_pkg::cross_t [3:0][2:0]              vb;
  logic [3:0][2:0][rti_pkg::W_PL-1:0]      pl_nxt, pl_r;
  logic [3:0][2:0][rti_pkg::W_PH-1:0]      ph_nxt, ph_r;
  rti_pkg::wide_t  [3:0][2:0]              cp_nxt, cp_r;
  rti_pkg::wide_t  [3:0]                   dt_nxt, dt_r;
  rti_pkg::wide_t  [3:0]                   nd_nxt, nd_r;
  logic                                    nz_nxt, nz_r;
  logic [3:0]                              last_r;
  rti_pkg::rti_cmp_t                       cmp_nxt, cmp_r;

  logic [W_D:0] uv;
  logic         u_ok, v_ok, uv_ok, t_ok;

  assign en[4] = !v_r[4] || dn_en;
  assign en[3] = !v_r[3] || en[4];
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign up_en = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_vld;
      for (int k = 1; k < 5; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_opnd
    assign va[0][i] = geo_in.e1[i];
    assign vb[0][i] = geo_in.h[i];
    assign va[1][i] = geo_in.s[i];
    assign vb[1][i] = geo_in.h[i];
    assign va[2][i] = {dir[i][rti_pkg::W_C-1], dir[i]};
    assign vb[2][i] = geo_in.q[i];
    assign va[3][i] = geo_in.e2[i];
    assign vb[3][i] = geo_in.q[i];
  end

  for (genvar k = 0; k < 4; k++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_comp
      assign pl_nxt[k][i] = rti_pkg::mul_lo(va[k][i], vb[k][i][rti_pkg::W_LO-1:0]);
      assign ph_nxt[k][i] = rti_pkg::mul_hi(va[k][i], vb[k][i][rti_pkg::W_X-1:rti_pkg::W_LO]);
      assign cp_nxt[k][i] =
        ({{(W_D-rti_pkg::W_PH){ph_r[k][i][rti_pkg::W_PH-1]}}, ph_r[k][i]} << rti_pkg::W_LO)
        + {{(W_D-rti_pkg::W_PL){pl_r[k][i][rti_pkg::W_PL-1]}}, pl_r[k][i]};
    end
    assign dt_nxt[k] = cp_r[k][0] + cp_r[k][1] + cp_r[k][2];
    // make the determinant positive, carry the others along
    assign nd_nxt[k] = dt_r[0][W_D-1] ? -dt_r[k] : dt_r[k];
  end

  assign nz_nxt = |dt_r[0];

  // nd_r: 0 det, 1 u, 2 v, 3 t
  always_comb begin
    u_ok  = !nd_r[1][W_D-1] && !($signed(nd_r[1]) > $signed(nd_r[0]));
    v_ok  = !nd_r[2][W_D-1];
    uv    = {nd_r[1][W_D-1], nd_r[1]} + {nd_r[2][W_D-1], nd_r[2]};
    uv_ok = !($signed(uv) > $signed({nd_r[0][W_D-1], nd_r[0]}));
    t_ok  = !nd_r[3][W_D-1] && (|nd_r[3]);
    cmp_nxt.det  = nd_r[0];
    cmp_nxt.t    = nd_r[3];
    cmp_nxt.pass = nz_r && u_ok && v_ok && uv_ok && t_ok;
    // quotient would reach 2^DIST_W
    cmp_nxt.sat  = {{rti_pkg::SAT_SH{1'b0}}, nd_r[3]} >= {nd_r[0], {rti_pkg::SAT_SH{1'b0}}};
    cmp_nxt.last = last_r[3];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pl_r      <= pl_nxt;
      ph_r      <= ph_nxt;
      last_r[0] <= geo_in.last;
    end
    if (en[1]) begin
      cp_r      <= cp_nxt;
      last_r[1] <= last_r[0];
    end
    if (en[2]) begin
      dt_r      <= dt_nxt;
      last_r[2] <= last_r[1];
    end
    if (en[3]) begin
      nd_r      <= nd_nxt;
      nz_r      <= nz_nxt;
      last_r[3] <= last_r[2];
    end
    if (en[4]) cmp_r <= cmp_nxt;
  end

  assign out_vld = v_r[4];
  assign cmp_out = cmp_r;

endmodule

`default_nettype wire

// ===== src/rti_div.sv =====
// ----------------------------------------------------------------------------
// rti_div : pipelined restoring divider and result formatting
// One quotient bit per stage for floor(t * 2^FRAC_BITS / det), then
// saturation, hit and occlusion flags into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire rti_pkg::rti_cmp_t             cmp_in,
  input  wire logic [rti_pkg::DIST_W-1:0]    max_dist,
  input  wire logic                          out_stall,
  output logic                               up_en,
  output logic                               out_vld,
  output logic                               hit,
  output logic [rti_pkg::DIST_W-1:0]         hit_dist,
  output logic                               occ,
  output logic                               last
);

  localparam int QN  = rti_pkg::DIST_W;
  localparam int W_D = rti_pkg::W_D;

  typedef struct packed {
    rti_pkg::wide_t              rem;
    rti_pkg::wide_t              det;
    logic [rti_pkg::SAT_SH-1:0]  tlo;
    logic [QN-1:0]               quo;
    logic                        pass;
    logic                        sat;
    logic                        last;
  } div_st_t;

  logic [QN:0]   v_r;
  logic [QN:0]   en;
  div_st_t       src   [QN];
  div_st_t       st_nxt[QN];
  div_st_t       st_r  [QN];

  logic [QN-1:0] dist_nxt;
  logic          hit_nxt, occ_nxt;
  logic          hit_r, occ_r, last_r;
  logic [QN-1:0] dist_r;

  assign en[QN] = !v_r[QN] || !out_stall;
  assign up_en  = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_vld;
      for (int k = 1; k <= QN; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // remainder starts at t >> SAT_SH, below det unless saturated
  always_comb begin
    src[0].rem  = cmp_in.t >> rti_pkg::SAT_SH;
    src[0].det  = cmp_in.det;
    src[0].tlo  = cmp_in.t[rti_pkg::SAT_SH-1:0];
    src[0].quo  = '0;
    src[0].pass = cmp_in.pass;
    src[0].sat  = cmp_in.sat;
    src[0].last = cmp_in.last;
  end

  for (genvar j = 0; j < QN; j++) begin : g_step
    localparam int I = QN - 1 - j;
    logic         nb;
    logic [W_D:0] rr, df;
    logic         ge;

    if (j > 0) begin : g_link
      assign src[j] = st_r[j-1];
    end

    if (j < QN - 1) begin : g_en
      assign en[j] = !v_r[j] || en[j+1];
    end else begin : g_en_last
      assign en[j] = !v_r[j] || en[QN];
    end

    if (I >= rti_pkg::FRAC_BITS) begin : g_tb
      assign nb = src[j].tlo[I-rti_pkg::FRAC_BITS];
    end else begin : g_zb
      assign nb = 1'b0;
    end

    always_comb begin
      rr = {src[j].rem, nb};
      df = rr - {1'b0, src[j].det};
      ge = rr >= {1'b0, src[j].det};
      st_nxt[j]        = src[j];
      st_nxt[j].rem    = ge ? df[W_D-1:0] : rr[W_D-1:0];
      st_nxt[j].quo[I] = ge;
    end

    always_ff @(posedge clk) begin
      if (en[j]) st_r[j] <= st_nxt[j];
    end
  end

  always_comb begin
    dist_nxt = st_r[QN-1].sat ? rti_pkg::DIST_MAX : st_r[QN-1].quo;
    hit_nxt  = st_r[QN-1].pass && (|dist_nxt);
    occ_nxt  = hit_nxt && (dist_nxt < max_dist);
  end

  always_ff @(posedge clk) begin
    if (en[QN]) begin
      hit_r  <= hit_nxt;
      dist_r <= hit_nxt ? dist_nxt : '0;
      occ_r  <= occ_nxt;
      last_r <= st_r[QN-1].last;
    end
  end

  assign out_vld  = v_r[QN];
  assign hit      = hit_r;
  assign hit_dist = dist_r;
  assign occ      = occ_r;
  assign last     = last_r;

endmodule

`default_nettype wire

// ===== src/ray_triangle_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect : Moller-Trumbore ray/triangle test, Q16.16
// Streams triangles against one ray held in configuration.
// ----------------------------------------------------------------------------
// Use:
//  - Write origin, direction and max distance through cfg_we/cfg_index/
//    cfg_data while the pipeline is empty; unknown indexes are dropped.
//  - Input channel: one triangle (three vertices plus last flag) per word,
//    taken when in_valid is high and in_stall low.
//  - Output channel: one word per triangle, in order: hit flag, hit
//    distance (0 when no hit, saturated at 2^31-1), occlusion flag, last.
//  - From acceptance to out_valid: 3 front, 5 dot, 31 divider steps,
//    1 output register. Throughput one word per cycle while out_stall
//    is low; the divider gives one quotient bit per stage.
//  - Each stage moves forward when empty or when the next one moves, so a
//    stall on out_stall fills the bubbles first and then backs up into
//    in_stall; no word is lost or repeated.
//  - Reset (rst_n low, synchronous) empties the pipeline and sets origin
//    and direction to zero and max distance to 2^31-1.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersect (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [rti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rti_pkg::CFG_W-1:0]         cfg_data,
  // triangle words
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [31:0]                       in_a_x,
  input  wire logic [31:0]                       in_a_y,
  input  wire logic [31:0]                       in_a_z,
  input  wire logic [31:0]                       in_b_x,
  input  wire logic [31:0]                       in_b_y,
  input  wire logic [31:0]                       in_b_z,
  input  wire logic [31:0]                       in_c_x,
  input  wire logic [31:0]                       in_c_y,
  input  wire logic [31:0]                       in_c_z,
  input  wire logic                              in_last_in,
  // result words
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_ray_hit,
  output logic [rti_pkg::DIST_W-1:0]             out_hit_distance,
  output logic                                   out_occludes,
  output logic                                   out_last_out
);

  // ray registers
  rti_pkg::coord_t [2:0]         org_r, dir_r;
  logic [rti_pkg::DIST_W-1:0]    max_r;

  rti_pkg::rti_tri_t  tri_w;
  rti_pkg::rti_geo_t  geo;
  rti_pkg::rti_cmp_t  cmp;
  logic               front_en, dot_en, div_en;
  logic               geo_vld, cmp_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r <= '0;
      dir_r <= '0;
      max_r <= rti_pkg::DIST_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        rti_pkg::REG_ORIGIN_X:    org_r[0] <= cfg_data;
        rti_pkg::REG_ORIGIN_Y:    org_r[1] <= cfg_data;
        rti_pkg::REG_ORIGIN_Z:    org_r[2] <= cfg_data;
        rti_pkg::REG_DIRECTION_X: dir_r[0] <= cfg_data;
        rti_pkg::REG_DIRECTION_Y: dir_r[1] <= cfg_data;
        rti_pkg::REG_DIRECTION_Z: dir_r[2] <= cfg_data;
        rti_pkg::REG_MAX_DIST:    max_r    <= cfg_data[rti_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // gather the triangle word
  assign tri_w.a    = {in_a_z, in_a_y, in_a_x};
  assign tri_w.b    = {in_b_z, in_b_y, in_b_x};
  assign tri_w.c    = {in_c_z, in_c_y, in_c_x};
  assign tri_w.last = in_last_in;

  assign in_stall = !front_en;

  // edges, h and q
  rti_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_valid),
    .tri_in  (tri_w),
    .org     (org_r),
    .dir     (dir_r),
    .dn_en   (dot_en),
    .up_en   (front_en),
    .out_vld (geo_vld),
    .geo_out (geo)
  );

  // det, u, v, t and the inside tests
  rti_dot u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (geo_vld),
    .geo_in  (geo),
    .dir     (dir_r),
    .dn_en   (div_en),
    .up_en   (dot_en),
    .out_vld (cmp_vld),
    .cmp_out (cmp)
  );

  // distance division and output register
  rti_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (cmp_vld),
    .cmp_in    (cmp),
    .max_dist  (max_r),
    .out_stall (out_stall),
    .up_en     (div_en),
    .out_vld   (out_valid),
    .hit       (out_ray_hit),
    .hit_dist  (out_hit_distance),
    .occ       (out_occludes),
    .last      (out_last_out)
  );

endmodule

`default_nettype wire

// ===== verif/ray_triangle_intersect_tb.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_tb : self-checking bench for the ray/triangle test
// Streams triangle words against several ray settings, predicts hit flag,
// distance and occlusion in wide exact arithmetic, and checks each result
// word in order under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersect_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] w_t;

  // one triangle word: v[0..2] vertex a, v[3..5] b, v[6..8] c
  typedef struct {
    logic [31:0] v[9];
    logic        last;
  } tri_word_t;

  typedef struct packed {
    logic                       hit;
    logic [rti_pkg::DIST_W-1:0] hdist;
    logic                       occ;
    logic                       last;
  } hit_word_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 50;

  // index beyond the register list
  localparam logic [rti_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rti_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [31:0] in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_c_x, in_c_y, in_c_z;
  logic in_last_in;
  logic out_valid;
  logic out_stall;
  logic out_ray_hit;
  logic [rti_pkg::DIST_W-1:0] out_hit_distance;
  logic out_occludes;
  logic out_last_out;

  // bench copy of the ray registers
  logic signed [31:0]         ray_org[3];
  logic signed [31:0]         ray_dir[3];
  logic [rti_pkg::DIST_W-1:0] ray_max;

  hit_word_t expected_hits[$];
  int  fail_cnt;
  bit  quiet;        // no gaps and no stalls while set
  int  stall_left;
  int  idle_cycles;

  ray_triangle_intersect u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_c_x(in_c_x), .in_c_y(in_c_y), .in_c_z(in_c_z),
    .in_last_in(in_last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ray_hit(out_ray_hit), .out_hit_distance(out_hit_distance),
    .out_occludes(out_occludes), .out_last_out(out_last_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: exact edges, cross and dot products, only t is rounded down
  // --------------------------------------------------------------------------
  function automatic w_t dot_w(input w_t p[3], input w_t r[3]);
    return p[0] * r[0] + p[1] * r[1] + p[2] * r[2];
  endfunction

  function automatic void cross_w(input w_t p[3], input w_t r[3], output w_t o[3]);
    o[0] = p[1] * r[2] - p[2] * r[1];
    o[1] = p[2] * r[0] - p[0] * r[2];
    o[2] = p[0] * r[1] - p[1] * r[0];
  endfunction

  function automatic hit_word_t predict_hit(input tri_word_t tr);
    w_t a[3], e1[3], e2[3], s[3], d[3], h[3], q[3];
    w_t det, u, v, t, quo;
    hit_word_t r;
    r = '0;
    r.last = tr.last;
    for (int i = 0; i < 3; i++) begin
      a[i]  = w_t'($signed(tr.v[i]));
      e1[i] = w_t'($signed(tr.v[3+i])) - a[i];
      e2[i] = w_t'($signed(tr.v[6+i])) - a[i];
      s[i]  = w_t'(ray_org[i]) - a[i];
      d[i]  = w_t'(ray_dir[i]);
    end
    cross_w(d, e2, h);
    cross_w(s, e1, q);
    det = dot_w(e1, h);
    u   = dot_w(s, h);
    v   = dot_w(d, q);
    t   = dot_w(e2, q);
    // zero determinant: parallel ray, flat triangle or null direction
    if (det != 0) begin
      if (det < 0) begin
        det = -det; u = -u; v = -v; t = -t;
      end
      // edges and corners count as inside; t must be strictly ahead
      if (u >= 0 && u <= det && v >= 0 && u + v <= det && t > 0) begin
        quo = (t <<< rti_pkg::FRAC_BITS) / det;
        r.hdist = (quo > w_t'({1'b0, rti_pkg::DIST_MAX})) ? rti_pkg::DIST_MAX
                                                          : quo[rti_pkg::DIST_W-1:0];
        if (r.hdist != 0) begin
          r.hit = 1'b1;
          r.occ = r.hdist < ray_max;
        end
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_tri(input tri_word_t tr);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_a_x <= tr.v[0]; in_a_y <= tr.v[1]; in_a_z <= tr.v[2];
    in_b_x <= tr.v[3]; in_b_y <= tr.v[4]; in_b_z <= tr.v[5];
    in_c_x <= tr.v[6]; in_c_y <= tr.v[7]; in_c_z <= tr.v[8];
    in_last_in <= tr.last;
    do @(posedge clk); while (in_stall);
    // the ray is steady while words are in flight, so predict on acceptance
    expected_hits.insert(expected_hits.size(), predict_hit(tr));
  endtask

  // Wait for the pipeline to drain; a word may still be in flight after the
  // last result, so allow the full latency before touching the registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rti_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rti_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      rti_pkg::REG_ORIGIN_X:    ray_org[0] = val;
      rti_pkg::REG_ORIGIN_Y:    ray_org[1] = val;
      rti_pkg::REG_ORIGIN_Z:    ray_org[2] = val;
      rti_pkg::REG_DIRECTION_X: ray_dir[0] = val;
      rti_pkg::REG_DIRECTION_Y: ray_dir[1] = val;
      rti_pkg::REG_DIRECTION_Z: ray_dir[2] = val;
      rti_pkg::REG_MAX_DIST:    ray_max    = val[rti_pkg::DIST_W-1:0];
      default: ;  // unused index, dropped by the block
    endcase
  endtask

  task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, input logic [31:0] mx);
    wait_drained();
    write_reg(rti_pkg::REG_ORIGIN_X, ox);
    write_reg(rti_pkg::REG_ORIGIN_Y, oy);
    write_reg(rti_pkg::REG_ORIGIN_Z, oz);
    write_reg(rti_pkg::REG_DIRECTION_X, dx);
    write_reg(rti_pkg::REG_DIRECTION_Y, dy);
    write_reg(rti_pkg::REG_DIRECTION_Z, dz);
    write_reg(rti_pkg::REG_MAX_DIST, mx);
  endtask

  function automatic tri_word_t mk_tri(input logic [31:0] ax, ay, az, bx, by, bz,
                                       cx, cy, cz, input logic last);
    tri_word_t tr;
    tr.v[0] = ax; tr.v[1] = ay; tr.v[2] = az;
    tr.v[3] = bx; tr.v[4] = by; tr.v[5] = bz;
    tr.v[6] = cx; tr.v[7] = cy; tr.v[8] = cz;
    tr.last = last;
    return tr;
  endfunction

  function automatic tri_word_t rand_tri();
    tri_word_t tr;
    for (int i = 0; i < 9; i++) tr.v[i] = $urandom();
    tr.last = $urandom_range(0, 1);
    return tr;
  endfunction

  // Triangle built around a point ahead on the ray, so most of these hit
  function automatic tri_word_t aimed_tri(input int k, input int spread);
    tri_word_t tr;
    logic signed [31:0] p;
    for (int i = 0; i < 3; i++) begin
      p = ray_org[i] + ray_dir[i] * k;
      tr.v[i]   = p + $signed($urandom_range(0, 2 * spread)) - spread;
      tr.v[3+i] = p + $signed($urandom_range(0, 2 * spread)) - spread;
      tr.v[6+i] = p + $signed($urandom_range(0, 2 * spread)) - spread;
    end
    tr.last = ($urandom_range(0, 7) == 0);
    return tr;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] NEG = 32'h8000_0000;
  localparam logic [31:0] POS = 32'h7FFF_FFFF;

  // reset ray has a null direction: nothing can hit
  task automatic test_reset_ray();
    send_tri(mk_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE, 1'b0));
    send_tri(mk_tri(NEG, NEG, NEG, POS, POS, POS, NEG, POS, 0, 1'b1));
  endtask

  task automatic test_directed();
    // ray along +z from the origin, plane z = 5
    set_ray(0, 0, 0, 0, 0, ONE, POS);
    send_tri(mk_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE, 1'b0));
    // reversed winding: negative determinant
    send_tri(mk_tri(-ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, 1'b1));
    // ray through a corner, then along an edge
    send_tri(mk_tri(0, 0, 5*ONE, 2*ONE, 0, 5*ONE, 0, 2*ONE, 5*ONE, 1'b0));
    send_tri(mk_tri(-ONE, 0, 5*ONE, ONE, 0, 5*ONE, 0, 2*ONE, 5*ONE, 1'b0));
    // just outside
    send_tri(mk_tri(1, 1, 5*ONE, 2*ONE, 1, 5*ONE, 1, 2*ONE, 5*ONE, 1'b0));
    // behind the origin, and the plane through the origin
    send_tri(mk_tri(-ONE, -ONE, -5*ONE, 2*ONE, -ONE, -5*ONE, -ONE, 2*ONE, -5*ONE, 1'b0));
    send_tri(mk_tri(-ONE, -ONE, 0, 2*ONE, -ONE, 0, -ONE, 2*ONE, 0, 1'b0));
    // parallel to the ray, and a flat (collinear) triangle
    send_tri(mk_tri(-ONE, 0, 0, ONE, 0, 0, 0, 0, 9*ONE, 1'b0));
    send_tri(mk_tri(0, 0, 5*ONE, ONE, ONE, 5*ONE, 2*ONE, 2*ONE, 5*ONE, 1'b1));
    // vertex extremes
    send_tri(mk_tri(NEG, NEG, POS, POS, NEG, POS, NEG, POS, POS, 1'b0));
    send_tri(mk_tri(POS, POS, NEG, NEG, POS, NEG, POS, NEG, NEG, 1'b1));

    // tiny direction: distance beyond range saturates, never occludes
    set_ray(0, 0, 0, 0, 0, 32'd1, POS);
    send_tri(mk_tri(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE, 1'b0));
    // huge direction, plane one step away: t rounds down to zero
    set_ray(0, 0, 0, 0, 0, POS, 32'd3 * ONE);
    send_tri(mk_tri(-ONE, -ONE, 32'd1, 2*ONE, -ONE, 32'd1, -ONE, 2*ONE, 32'd1, 1'b0));
    send_tri(mk_tri(-ONE, -ONE, POS, 2*ONE, -ONE, POS, -ONE, 2*ONE, POS, 1'b1));

    // occlusion limit either side of the hit, then zero limit
    set_ray(NEG, ONE, 0, ONE, 0, 0, 32'd5 * ONE);
    send_tri(mk_tri(NEG + 5*ONE, 0, -ONE, NEG + 5*ONE, 3*ONE, -ONE,
                    NEG + 5*ONE, 0, 3*ONE, 1'b0));
    send_tri(mk_tri(NEG + 4*ONE, 0, -ONE, NEG + 4*ONE, 3*ONE, -ONE,
                    NEG + 4*ONE, 0, 3*ONE, 1'b0));
    set_ray(NEG, ONE, 0, ONE, 0, 0, 32'h8000_0000);
    write_reg(REG_SPARE, $urandom());
    send_tri(mk_tri(NEG + 4*ONE, 0, -ONE, NEG + 4*ONE, 3*ONE, -ONE,
                    NEG + 4*ONE, 0, 3*ONE, 1'b1));
  endtask

  // random rays, mostly aimed triangles with some full-range noise
  task automatic test_random();
    int spread;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_ray($urandom_range(0, 1 << 20) - (1 << 19), $urandom_range(0, 1 << 20),
                   $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 17) - (1 << 16),
                   $urandom_range(0, 1 << 17) - (1 << 16), ONE, $urandom());
        1: set_ray(POS - (1 << 24), NEG + (1 << 24), 0, $urandom_range(0, 1 << 16),
                   ONE, $urandom_range(0, 1 << 16), POS);
        2: set_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   32'h0);
        default: set_ray($urandom_range(0, 1 << 22) - (1 << 21),
                         $urandom_range(0, 1 << 22) - (1 << 21),
                         $urandom_range(0, 1 << 22) - (1 << 21),
                         $urandom_range(0, 1 << 18) - (1 << 17),
                         $urandom_range(0, 1 << 18) - (1 << 17),
                         $urandom_range(0, 1 << 18) - (1 << 17),
                         $urandom_range(0, 40) * ONE);
      endcase
      quiet = (ph == 3);
      for (int n = 0; n < 100; n++) begin
        spread = 1 << $urandom_range(8, 20);
        if ($urandom_range(0, 9) < 3) send_tri(rand_tri());
        else send_tri(aimed_tri($urandom_range(0, 30) - 4, spread));
      end
      quiet = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker and stall generator
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    hit_word_t exp_w;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected result word");
          fail_cnt++;
        end else begin
          exp_w = expected_hits.pop_front();
          if (out_ray_hit !== exp_w.hit) begin
            $error("ray_hit: expected %0d, got %0d", exp_w.hit, out_ray_hit);
            fail_cnt++;
          end
          if (out_hit_distance !== exp_w.hdist) begin
            $error("hit_distance: expected %0h, got %0h", exp_w.hdist, out_hit_distance);
            fail_cnt++;
          end
          if (out_occludes !== exp_w.occ) begin
            $error("occludes: expected %0d, got %0d", exp_w.occ, out_occludes);
            fail_cnt++;
          end
          if (out_last_out !== exp_w.last) begin
            $error("last_out: expected %0d, got %0d", exp_w.last, out_last_out);
            fail_cnt++;
          end
        end
        stall_left = quiet ? 0 : $urandom_range(0, 12);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    fail_cnt = 0;
    quiet = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_last_in = 1'b0;
    in_a_x = '0; in_a_y = '0; in_a_z = '0;
    in_b_x = '0; in_b_y = '0; in_b_z = '0;
    in_c_x = '0; in_c_y = '0; in_c_z = '0;
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = '0;
      ray_dir[i] = '0;
    end
    ray_max = rti_pkg::DIST_MAX;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_ray();
    test_directed();
    test_random();

    wait_drained();
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/rti_pkg.sv
src/rti_front.sv
src/rti_dot.sv
src/rti_div.sv
src/ray_triangle_intersect.sv
verif/ray_triangle_intersect_tb.sv
